// ----- rtl/core/sic_pkg.sv -----
// Shared constants, codes and item types for the interval clustering block.
`timescale 1ns / 1ps
package sic_pkg;

  // Default widths of the fixed-point datapath
  localparam int FRAME_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int FIELD_W      = 32;
  localparam int DEV_W        = 24;
  localparam int FT_W         = 10;
  localparam int MIN_W        = 16;
  localparam int TOTAL_W      = 16;
  localparam int OUT_CNT_W    = 16;
  localparam int OUT_CENTER_W = 40;
  localparam int CFG_DATA_W   = 24;

  // Register values after reset
  localparam logic [DEV_W-1:0] START_DEV_RST = 24'd1000;
  localparam logic [DEV_W-1:0] END_DEV_RST   = 24'd1000;
  localparam logic [FT_W-1:0]  FT_RST        = 10'd40;
  localparam logic [MIN_W-1:0] MIN_SIZE_RST  = 16'd5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    CFG_START_DEV,
    CFG_END_DEV,
    CFG_FRAME_TIME,
    CFG_MIN_SIZE
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] start_frame;
    logic [FIELD_W-1:0] end_frame;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic                    started_new;
    logic [OUT_CNT_W-1:0]    member_position;
    logic                    closed_valid;
    logic [OUT_CNT_W-1:0]    closed_size;
    logic                    closed_accepted;
    logic [OUT_CNT_W-1:0]    accepted_count;
    logic [OUT_CNT_W-1:0]    final_size;
    logic                    final_accepted;
    logic [OUT_CENTER_W-1:0] center_start_out;
    logic [OUT_CENTER_W-1:0] center_end_out;
  } out_item_t;

  // Sequencing strobes from the controller to one axis
  typedef struct packed {
    logic load;
    logic mul_step;
    logic div_step;
  } axis_ctrl_t;

endpackage

// ----- rtl/core/sequential_interval_clustering.sv -----
// An accepted item passes through LOAD, RUN and UPDATE, and UPDATE waits while an earlier result
// is still pending; a new item is taken only back in IDLE. The length of RUN is set by the
// bit-serial distance-times-frame-time multiply and compare over all product bits; both
// running-mean divisions run alongside it, one quotient bit per cycle.
// Reset (synchronous): no open cluster, centers and accepted total zero, registers at
// deviations 1000, frame time 40, minimum size 5.
`timescale 1ns / 1ps
module sequential_interval_clustering #(
  parameter int FRAME_BITS = sic_pkg::FRAME_BITS_DEF,
  parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = sic_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sic_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sic_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  sic_pkg::cfg_index_t            cfg_index,
  input  logic [sic_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW     = FRAME_BITS + FRAC_BITS;
  localparam int PW     = CW + sic_pkg::FT_W;
  localparam int STEP_W = $clog2(PW);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration registers
  logic [sic_pkg::DEV_W-1:0]   start_spread;
  logic [sic_pkg::DEV_W-1:0]   end_spread;
  logic [sic_pkg::FT_W-1:0]    frame_time;
  logic [sic_pkg::MIN_W-1:0]   min_size;

  // Cluster state
  logic [CW-1:0]               center_start;
  logic [CW-1:0]               center_end;
  logic [COUNT_BITS-1:0]       member_count;
  logic [sic_pkg::TOTAL_W-1:0] accepted_total;

  // Item under work
  logic [CW-1:0]               pos_s;
  logic [CW-1:0]               pos_e;
  logic                        last_q;

  sic_pkg::state_t             state;
  sic_pkg::state_t             state_next;
  logic [STEP_W-1:0]           cnt;
  sic_pkg::axis_ctrl_t         ctrl;
  logic                        accept;
  logic                        upd_fire;

  logic [63:0]                 sf_wide;
  logic [63:0]                 ef_wide;
  logic [CW-1:0]               pos_s_in;
  logic [CW-1:0]               pos_e_in;

  logic [COUNT_BITS-1:0]       count_inc;
  logic                        near_s;
  logic                        near_e;
  logic [CW-1:0]               moved_s;
  logic [CW-1:0]               moved_e;

  logic                        joins;
  logic                        started;
  logic                        cvalid;
  logic                        cacc;
  logic                        facc;
  logic [COUNT_BITS-1:0]       mc1;
  logic [CW-1:0]               cs1;
  logic [CW-1:0]               ce1;
  logic [sic_pkg::TOTAL_W-1:0] total1;
  logic [sic_pkg::TOTAL_W-1:0] total2;
  logic [COUNT_BITS-1:0]       member_count_next;
  logic [CW-1:0]               center_start_next;
  logic [CW-1:0]               center_end_next;
  sic_pkg::out_item_t          out_next;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Place frames in fixed point, taken modulo 2^FRAME_BITS
  assign sf_wide  = 64'(in_data.start_frame);
  assign ef_wide  = 64'(in_data.end_frame);
  assign pos_s_in = {sf_wide[FRAME_BITS-1:0], FRAC_BITS'(0)};
  assign pos_e_in = {ef_wide[FRAME_BITS-1:0], FRAC_BITS'(0)};

  // Divide by the count the cluster would have after a join
  assign count_inc = (member_count == COUNT_MAX) ? member_count : member_count + 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_spread <= sic_pkg::START_DEV_RST;
      end_spread   <= sic_pkg::END_DEV_RST;
      frame_time   <= sic_pkg::FT_RST;
      min_size     <= sic_pkg::MIN_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sic_pkg::CFG_START_DEV:  start_spread <= cfg_data[sic_pkg::DEV_W-1:0];
        sic_pkg::CFG_END_DEV:    end_spread   <= cfg_data[sic_pkg::DEV_W-1:0];
        sic_pkg::CFG_FRAME_TIME: frame_time   <= cfg_data[sic_pkg::FT_W-1:0];
        sic_pkg::CFG_MIN_SIZE:   min_size     <= cfg_data[sic_pkg::MIN_W-1:0];
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sic_pkg::ST_IDLE:   if (accept) state_next = sic_pkg::ST_LOAD;
      sic_pkg::ST_LOAD:   state_next = sic_pkg::ST_RUN;
      sic_pkg::ST_RUN:    if (cnt == STEP_W'(PW - 1)) state_next = sic_pkg::ST_UPDATE;
      sic_pkg::ST_UPDATE: if (!out_valid || out_ready) state_next = sic_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready      = 1'b0;
    ctrl.load     = 1'b0;
    ctrl.mul_step = 1'b0;
    ctrl.div_step = 1'b0;
    upd_fire      = 1'b0;
    unique case (state)
      sic_pkg::ST_IDLE:   in_ready = 1'b1;
      sic_pkg::ST_LOAD:   ctrl.load = 1'b1;
      sic_pkg::ST_RUN: begin
        ctrl.mul_step = 1'b1;
        ctrl.div_step = cnt < STEP_W'(CW);
      end
      sic_pkg::ST_UPDATE: upd_fire = !out_valid || out_ready;
    endcase
  end

  // Advance state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sic_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (ctrl.load) begin
        cnt <= '0;
      end else if (ctrl.mul_step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_s  <= pos_s_in;
      pos_e  <= pos_e_in;
      last_q <= in_data.last_item;
    end
  end

  sic_axis #(
    .FRAME_BITS (FRAME_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_axis_start (
    .clk        (clk),
    .ctrl       (ctrl),
    .pos_q      (pos_s),
    .center     (center_start),
    .dev        (start_spread),
    .frame_time (frame_time),
    .divisor    (count_inc),
    .near       (near_s),
    .moved      (moved_s)
  );

  sic_axis #(
    .FRAME_BITS (FRAME_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_axis_end (
    .clk        (clk),
    .ctrl       (ctrl),
    .pos_q      (pos_e),
    .center     (center_end),
    .dev        (end_spread),
    .frame_time (frame_time),
    .divisor    (count_inc),
    .near       (near_e),
    .moved      (moved_e)
  );

  // Decide join or close, then apply the flush of the last item
  always_comb begin
    joins   = (member_count != '0) && near_s && near_e;
    started = !joins;
    cvalid  = !joins && (member_count != '0);
    cacc    = cvalid && (32'(member_count) >= 32'(min_size));
    total1  = (cacc && accepted_total != sic_pkg::TOTAL_MAX) ?
              accepted_total + 1'b1 : accepted_total;
    mc1     = joins ? count_inc : COUNT_BITS'(1);
    cs1     = joins ? moved_s : pos_s;
    ce1     = joins ? moved_e : pos_e;
    facc    = last_q && (32'(mc1) >= 32'(min_size));
    total2  = (facc && total1 != sic_pkg::TOTAL_MAX) ? total1 + 1'b1 : total1;

    member_count_next = last_q ? '0 : mc1;
    center_start_next = last_q ? '0 : cs1;
    center_end_next   = last_q ? '0 : ce1;

    out_next.started_new      = started;
    out_next.member_position  = sic_pkg::OUT_CNT_W'(32'(mc1));
    out_next.closed_valid     = cvalid;
    out_next.closed_size      = cvalid ? sic_pkg::OUT_CNT_W'(32'(member_count)) : '0;
    out_next.closed_accepted  = cacc;
    out_next.accepted_count   = total2;
    out_next.final_size       = last_q ? sic_pkg::OUT_CNT_W'(32'(mc1)) : '0;
    out_next.final_accepted   = facc;
    out_next.center_start_out = sic_pkg::OUT_CENTER_W'(64'(cs1));
    out_next.center_end_out   = sic_pkg::OUT_CENTER_W'(64'(ce1));
  end

  // Commit cluster state
  always_ff @(posedge clk) begin
    if (rst) begin
      center_start   <= '0;
      center_end     <= '0;
      member_count   <= '0;
      accepted_total <= '0;
    end else if (upd_fire) begin
      center_start   <= center_start_next;
      center_end     <= center_end_next;
      member_count   <= member_count_next;
      accepted_total <= total2;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_data <= out_next;
    end
  end

  // A pending result must not be overwritten
  a_hold_update: assert property (@(posedge clk) disable iff (rst)
    state == sic_pkg::ST_UPDATE && out_valid && !out_ready |=> state == sic_pkg::ST_UPDATE)
    else $error("update left while result still pending");

  // A flush leaves no open cluster
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    upd_fire && last_q |=> member_count == '0 && center_start == '0 && center_end == '0)
    else $error("flush did not clear the cluster");

  // Without a flush a cluster stays open
  a_open_after: assert property (@(posedge clk) disable iff (rst)
    upd_fire && !last_q |=> member_count != '0)
    else $error("no open cluster after a non-final item");

  // The accepted total never falls
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> accepted_total >= $past(accepted_total))
    else $error("accepted total decreased");

  // A new cluster has one member, and a close always opens a new one
  a_new_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.started_new || out_data.member_position == 16'd1) &&
                  (!out_data.closed_valid || out_data.started_new))
    else $error("inconsistent new cluster report");

endmodule

// ----- rtl/core/sic_near.sv -----
// Bit-serial distance-times-frame-time multiplier with a serial compare against the bound.
`timescale 1ns / 1ps
module sic_near #(
  parameter int CENTER_W  = sic_pkg::FRAME_BITS_DEF + sic_pkg::FRAC_BITS_DEF,
  parameter int FRAC_BITS = sic_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  sic_pkg::axis_ctrl_t        ctrl,
  input  logic [CENTER_W-1:0]        offset,
  input  logic [sic_pkg::DEV_W-1:0]  dev,
  input  logic [sic_pkg::FT_W-1:0]   frame_time,
  output logic                       near
);

  localparam int PROD_W = CENTER_W + sic_pkg::FT_W;

  logic [PROD_W-1:0]            dev_ext;
  logic [PROD_W-1:0]            bound;
  logic [CENTER_W-1:0]          mcand;
  logic [sic_pkg::FT_W-1:0]     acc;
  logic [PROD_W-1:0]            bnd;
  logic                         lt;
  logic [sic_pkg::FT_W:0]       sum;
  logic                         p_bit;
  logic                         b_bit;
  logic                         lt_next;

  // Scale the deviation by 2.5 in fixed point: dev * 5 * 2^(FRAC_BITS-1)
  assign dev_ext = PROD_W'(dev);
  assign bound   = (dev_ext + (dev_ext << 2)) << (FRAC_BITS - 1);

  // Add frame_time for each distance bit; emit one product bit per step
  assign sum     = {1'b0, acc} + (mcand[0] ? {1'b0, frame_time} : '0);
  assign p_bit   = sum[0];
  assign b_bit   = bnd[0];
  // LSB-first less-than: a higher differing bit overrides the lower verdict
  assign lt_next = (~p_bit & b_bit) | (~(p_bit ^ b_bit) & lt);

  // Load operands, then shift one product bit out per step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mcand <= offset;
      acc   <= '0;
      bnd   <= bound;
      lt    <= 1'b0;
    end else if (ctrl.mul_step) begin
      mcand <= mcand >> 1;
      acc   <= sum[sic_pkg::FT_W:1];
      bnd   <= bnd >> 1;
      lt    <= lt_next;
    end
  end

  assign near = lt;

endmodule

// ----- rtl/core/sic_div.sv -----
// Restoring divider that retires one quotient bit per step.
`timescale 1ns / 1ps
module sic_div #(
  parameter int CENTER_W   = sic_pkg::FRAME_BITS_DEF + sic_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = sic_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  sic_pkg::axis_ctrl_t   ctrl,
  input  logic [CENTER_W-1:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic [CENTER_W-1:0]   quotient
);

  logic [CENTER_W-1:0]   dq;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  fits;

  // Bring down the next dividend bit and try the subtract
  assign trial = {rem, dq[CENTER_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = ~diff[COUNT_BITS];

  // Shift quotient bits in as dividend bits leave
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (ctrl.div_step) begin
      rem <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      dq  <= {dq[CENTER_W-2:0], fits};
    end
  end

  assign quotient = dq;

endmodule

// ----- rtl/core/sic_axis.sv -----
// One axis of the center: distance, join test and running-mean move.
`timescale 1ns / 1ps
module sic_axis #(
  parameter int FRAME_BITS = sic_pkg::FRAME_BITS_DEF,
  parameter int FRAC_BITS  = sic_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = sic_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  sic_pkg::axis_ctrl_t                 ctrl,
  input  logic [FRAME_BITS+FRAC_BITS-1:0]     pos_q,
  input  logic [FRAME_BITS+FRAC_BITS-1:0]     center,
  input  logic [sic_pkg::DEV_W-1:0]           dev,
  input  logic [sic_pkg::FT_W-1:0]            frame_time,
  input  logic [COUNT_BITS-1:0]               divisor,
  output logic                                near,
  output logic [FRAME_BITS+FRAC_BITS-1:0]     moved
);

  localparam int CW = FRAME_BITS + FRAC_BITS;

  logic          up_c;
  logic          up;
  logic [CW-1:0] offset;
  logic [CW-1:0] quot;

  // Absolute distance between item and center
  assign up_c   = pos_q >= center;
  assign offset = up_c ? pos_q - center : center - pos_q;

  // Hold the direction of the move for the update
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      up <= up_c;
    end
  end

  sic_near #(
    .CENTER_W  (CW),
    .FRAC_BITS (FRAC_BITS)
  ) u_near (
    .clk        (clk),
    .ctrl       (ctrl),
    .offset     (offset),
    .dev        (dev),
    .frame_time (frame_time),
    .near       (near)
  );

  sic_div #(
    .CENTER_W   (CW),
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .ctrl     (ctrl),
    .dividend (offset),
    .divisor  (divisor),
    .quotient (quot)
  );

  // Step the center toward the item by the truncated quotient
  assign moved = up ? center + quot : center - quot;

endmodule
